### rtl/mwem_pkg.sv
`default_nettype none

package mwem_pkg;

   localparam int DATA_BITS        = 16;
   localparam int MAX_ADDR_BITS    = 8;
   localparam int NARROW_ADDR_BITS = 6;
   localparam int CMD_BITS         = 3 + MAX_ADDR_BITS + DATA_BITS;
   localparam int NBITS_W          = 5;
   localparam int OP_W             = 3;
   localparam int HP_W             = 8;
   localparam int TMO_W            = 20;
   localparam int STATUS_W         = 2;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 20;

   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE = 3'd3;
   localparam logic [OP_W-1:0] OP_WREN  = 3'd4;
   localparam logic [OP_W-1:0] OP_WRDS  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BUSY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_READY = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_ADDR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PER  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_TMO  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_READY_TMO = 2'd3;

   localparam logic [HP_W-1:0]  HALF_PER_RESET  = 8'd2;
   localparam logic [TMO_W-1:0] BUSY_TMO_RESET  = 20'd1500;
   localparam logic [TMO_W-1:0] READY_TMO_RESET = 20'd15000;

   localparam int Q_DEPTH = 2;

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_SETUP      = 10'b00_0000_0010,
      PH_BIT_LOW    = 10'b00_0000_0100,
      PH_BIT_HIGH   = 10'b00_0000_1000,
      PH_RELEASE    = 10'b00_0001_0000,
      PH_RD_HIGH    = 10'b00_0010_0000,
      PH_RD_LOW     = 10'b00_0100_0000,
      PH_CS_DROP    = 10'b00_1000_0000,
      PH_WAIT_BUSY  = 10'b01_0000_0000,
      PH_WAIT_READY = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic                start;
      logic                is_read;
      logic                is_prog;
      logic [CMD_BITS-1:0] cmd;
      logic [NBITS_W-1:0]  nbits;
      logic                sdo;
   } item_type;

   typedef struct packed {
      logic [HP_W-1:0]  half_per;
      logic [TMO_W-1:0] busy_tmo;
      logic [TMO_W-1:0] ready_tmo;
   } timing_type;

   typedef struct packed {
      logic                 pm;
      logic                 cs;
      logic                 sk;
      logic                 di;
      logic                 done;
      logic [DATA_BITS-1:0] read_word;
      logic [STATUS_W-1:0]  status;
   } result_type;

endpackage

`default_nettype wire

### rtl/mwem_front.sv
`default_nettype none

module mwem_front (
   input  wire logic [mwem_pkg::OP_W-1:0]          op,
   input  wire logic [mwem_pkg::MAX_ADDR_BITS-1:0] word_address,
   input  wire logic [mwem_pkg::DATA_BITS-1:0]     write_word,
   input  wire logic                               serial_data_out,
   input  wire logic                               wide_address,
   output mwem_pkg::item_type                      item
);

   logic [mwem_pkg::CMD_BITS-1:0] addr_ext;
   logic [mwem_pkg::CMD_BITS-1:0] data_ext;
   logic [mwem_pkg::NBITS_W-1:0]  addr_bits;

   function automatic logic [mwem_pkg::CMD_BITS-1:0] prefix(
      input logic [2:0] code,
      input logic       wide
   );
      logic [mwem_pkg::CMD_BITS-1:0] x;
      x = mwem_pkg::CMD_BITS'(code);
      return wide ? (x << mwem_pkg::MAX_ADDR_BITS) : (x << mwem_pkg::NARROW_ADDR_BITS);
   endfunction

   always_comb begin
      addr_ext  = wide_address ? mwem_pkg::CMD_BITS'(word_address)
                               : mwem_pkg::CMD_BITS'(word_address[mwem_pkg::NARROW_ADDR_BITS-1:0]);
      data_ext  = mwem_pkg::CMD_BITS'(write_word);
      addr_bits = wide_address ? mwem_pkg::NBITS_W'(mwem_pkg::MAX_ADDR_BITS)
                               : mwem_pkg::NBITS_W'(mwem_pkg::NARROW_ADDR_BITS);

      item.start   = 1'b0;
      item.is_read = 1'b0;
      item.is_prog = 1'b0;
      item.sdo     = serial_data_out;
      item.cmd     = prefix(3'd4, wide_address);
      item.nbits   = addr_bits + 5'd3;

      unique case (op)
         mwem_pkg::OP_READ: begin
            item.start   = 1'b1;
            item.is_read = 1'b1;
            item.cmd     = prefix(3'd6, wide_address) | addr_ext;
            item.nbits   = addr_bits + 5'd5;
         end
         mwem_pkg::OP_WRITE: begin
            item.start   = 1'b1;
            item.is_prog = 1'b1;
            item.cmd     = ((prefix(3'd5, wide_address) | addr_ext) << mwem_pkg::DATA_BITS)
                           | data_ext;
            item.nbits   = addr_bits + 5'd3 + mwem_pkg::NBITS_W'(mwem_pkg::DATA_BITS);
         end
         mwem_pkg::OP_ERASE: begin
            item.start   = 1'b1;
            item.is_prog = 1'b1;
            item.cmd     = prefix(3'd7, wide_address) | addr_ext;
         end
         mwem_pkg::OP_WREN: begin
            item.start = 1'b1;
            item.cmd   = prefix(3'd4, wide_address)
                         | (wide_address
                            ? (mwem_pkg::CMD_BITS'(8'h30)
                               << (mwem_pkg::MAX_ADDR_BITS - mwem_pkg::NARROW_ADDR_BITS))
                            : mwem_pkg::CMD_BITS'(8'h30));
         end
         mwem_pkg::OP_WRDS: begin
            item.start = 1'b1;
         end
         default: begin
            item.start = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/mwem_queue.sv
`default_nettype none

module mwem_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  mwem_pkg::item_type push_data,
   output logic              not_full,
   input  wire logic         pop,
   output mwem_pkg::item_type pop_data,
   output logic              not_empty
);

   localparam int PTR_W = $clog2(mwem_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(mwem_pkg::Q_DEPTH + 1);

   mwem_pkg::item_type mem_ff [mwem_pkg::Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full  = (count_ff != CNT_W'(mwem_pkg::Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(mwem_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/mwem_back.sv
`default_nettype none

module mwem_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           item_valid,
   input  mwem_pkg::item_type  item,
   output logic                item_pop,
   input  mwem_pkg::timing_type timing,
   output logic                res_valid,
   input  wire logic           res_ready,
   output mwem_pkg::result_type res
);

   mwem_pkg::phase_type phase_ff, phase_in;
   logic is_read_ff, is_read_in;
   logic is_prog_ff, is_prog_in;
   logic [mwem_pkg::CMD_BITS-1:0]  shift_out_ff, shift_out_in;
   logic [mwem_pkg::NBITS_W-1:0]   bits_ff, bits_in;
   logic [mwem_pkg::DATA_BITS-1:0] shift_in_ff, shift_in_in;
   logic [mwem_pkg::HP_W-1:0]      delay_ff, delay_in;
   logic [mwem_pkg::TMO_W-1:0]     wait_ff, wait_in;
   logic [mwem_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                           out_valid_ff, out_valid_in;
   mwem_pkg::result_type           res_ff, res_in;

   logic [mwem_pkg::HP_W-1:0]    hp1;
   logic [mwem_pkg::TMO_W-1:0]   busy1;
   logic [mwem_pkg::TMO_W-1:0]   ready1;
   logic                         elapsed;
   logic                         done;
   logic [mwem_pkg::NBITS_W-1:0] bits_dec;
   logic [mwem_pkg::NBITS_W-1:0] di_idx;

   assign item_pop  = item_valid && (!out_valid_ff || res_ready);
   assign res_valid = out_valid_ff;
   assign res       = res_ff;

   always_comb begin
      hp1      = (timing.half_per == '0) ? mwem_pkg::HP_W'(1) : timing.half_per;
      busy1    = (timing.busy_tmo == '0) ? mwem_pkg::TMO_W'(1) : timing.busy_tmo;
      ready1   = (timing.ready_tmo == '0) ? mwem_pkg::TMO_W'(1) : timing.ready_tmo;
      elapsed  = (delay_ff <= mwem_pkg::HP_W'(1));
      bits_dec = (bits_ff != '0) ? bits_ff - 1'b1 : '0;

      phase_in     = phase_ff;
      is_read_in   = is_read_ff;
      is_prog_in   = is_prog_ff;
      shift_out_in = shift_out_ff;
      bits_in      = bits_ff;
      shift_in_in  = shift_in_ff;
      delay_in     = elapsed ? delay_ff : delay_ff - 1'b1;
      wait_in      = wait_ff;
      status_in    = status_ff;
      done         = 1'b0;

      unique case (phase_ff)
         mwem_pkg::PH_IDLE: begin
            delay_in = delay_ff;
            if (item.start) begin
               is_read_in   = item.is_read;
               is_prog_in   = item.is_prog;
               shift_out_in = item.cmd;
               bits_in      = item.nbits;
               phase_in     = mwem_pkg::PH_SETUP;
               delay_in     = hp1;
            end
         end
         mwem_pkg::PH_SETUP: begin
            if (elapsed) begin
               phase_in = (bits_ff != '0) ? mwem_pkg::PH_BIT_LOW : mwem_pkg::PH_RELEASE;
               delay_in = hp1;
            end
         end
         mwem_pkg::PH_BIT_LOW: begin
            if (elapsed) begin
               phase_in = mwem_pkg::PH_BIT_HIGH;
               delay_in = hp1;
            end
         end
         mwem_pkg::PH_BIT_HIGH: begin
            if (elapsed) begin
               bits_in  = bits_dec;
               phase_in = (bits_dec != '0) ? mwem_pkg::PH_BIT_LOW : mwem_pkg::PH_RELEASE;
               delay_in = hp1;
            end
         end
         mwem_pkg::PH_RELEASE: begin
            if (elapsed) begin
               if (is_read_ff) begin
                  shift_in_in = '0;
                  bits_in     = mwem_pkg::NBITS_W'(mwem_pkg::DATA_BITS);
                  phase_in    = mwem_pkg::PH_RD_HIGH;
                  delay_in    = hp1;
               end else if (is_prog_ff) begin
                  phase_in = mwem_pkg::PH_CS_DROP;
                  delay_in = hp1;
               end else begin
                  status_in = mwem_pkg::ST_OK;
                  phase_in  = mwem_pkg::PH_IDLE;
                  done      = 1'b1;
               end
            end
         end
         mwem_pkg::PH_RD_HIGH: begin
            if (elapsed) begin
               shift_in_in = {shift_in_ff[mwem_pkg::DATA_BITS-2:0], item.sdo};
               phase_in    = mwem_pkg::PH_RD_LOW;
               delay_in    = hp1;
            end
         end
         mwem_pkg::PH_RD_LOW: begin
            if (elapsed) begin
               bits_in = bits_dec;
               if (bits_dec != '0) begin
                  phase_in = mwem_pkg::PH_RD_HIGH;
                  delay_in = hp1;
               end else begin
                  status_in = mwem_pkg::ST_OK;
                  phase_in  = mwem_pkg::PH_IDLE;
                  done      = 1'b1;
               end
            end
         end
         mwem_pkg::PH_CS_DROP: begin
            if (elapsed) begin
               phase_in = mwem_pkg::PH_WAIT_BUSY;
               wait_in  = busy1;
            end
         end
         mwem_pkg::PH_WAIT_BUSY: begin
            delay_in = delay_ff;
            if (!item.sdo) begin
               phase_in = mwem_pkg::PH_WAIT_READY;
               wait_in  = ready1;
            end else if (wait_ff <= mwem_pkg::TMO_W'(1)) begin
               status_in = mwem_pkg::ST_NO_BUSY;
               phase_in  = mwem_pkg::PH_IDLE;
               done      = 1'b1;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         mwem_pkg::PH_WAIT_READY: begin
            delay_in = delay_ff;
            if (item.sdo) begin
               status_in = mwem_pkg::ST_OK;
               phase_in  = mwem_pkg::PH_IDLE;
               done      = 1'b1;
            end else if (wait_ff <= mwem_pkg::TMO_W'(1)) begin
               status_in = mwem_pkg::ST_NO_READY;
               phase_in  = mwem_pkg::PH_IDLE;
               done      = 1'b1;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         default: begin
            delay_in = delay_ff;
            phase_in = mwem_pkg::PH_IDLE;
         end
      endcase

      di_idx           = bits_in - 1'b1;
      res_in.pm        = (phase_in != mwem_pkg::PH_IDLE);
      res_in.cs        = (phase_in != mwem_pkg::PH_IDLE) && (phase_in != mwem_pkg::PH_CS_DROP);
      res_in.sk        = (phase_in == mwem_pkg::PH_BIT_HIGH) || (phase_in == mwem_pkg::PH_RD_HIGH);
      res_in.di        = ((phase_in == mwem_pkg::PH_BIT_LOW) || (phase_in == mwem_pkg::PH_BIT_HIGH))
                         && (bits_in != '0)
                         && (bits_in <= mwem_pkg::NBITS_W'(mwem_pkg::CMD_BITS))
                         && shift_out_in[di_idx];
      res_in.done      = done;
      res_in.read_word = shift_in_in;
      res_in.status    = status_in;

      out_valid_in = item_pop ? 1'b1 : (res_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         res_ff       <= res_in;
         is_read_ff   <= is_read_in;
         is_prog_ff   <= is_prog_in;
         shift_out_ff <= shift_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mwem_pkg::PH_IDLE;
         bits_ff      <= '0;
         shift_in_ff  <= '0;
         delay_ff     <= '0;
         wait_ff      <= '0;
         status_ff    <= mwem_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            phase_ff    <= phase_in;
            bits_ff     <= bits_in;
            shift_in_ff <= shift_in_in;
            delay_ff    <= delay_in;
            wait_ff     <= wait_in;
            status_ff   <= status_in;
         end
      end
   end

   a_done_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.done |-> !res_ff.pm)
      else $error("command finished but interface still in program mode");

   a_clock_needs_select: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.sk |-> res_ff.cs)
      else $error("serial clock high while chip select low");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      item_pop && (phase_ff == mwem_pkg::PH_IDLE) && !item.start
      |=> (phase_ff == mwem_pkg::PH_IDLE))
      else $error("sequencer left idle without a command");

endmodule

`default_nettype wire

### rtl/microwire_eeprom_master_core.sv
// results are registered as the sequencer pops items; a low rsp_tready holds them
// throughput: one item per cycle unless rsp_tready stalls; each item is one sequencer tick
// a two-entry queue between classifier and sequencer absorbs short stalls on either side
// reset: synchronous, active high; sequencer idle, status ok, registers back to defaults
// configuration writes are registered and always ready
`default_nettype none

module microwire_eeprom_master_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[2:0], word_address[10:3], write_word[26:11], serial_data_out[27], zero fill
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // program_mode[0], chip_select[1], serial_clock[2], serial_data_in[3], busy_res[4],
   // done_res[5], read_word[21:6], status[23:22]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [mwem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mwem_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                        wide_ff;
   logic [mwem_pkg::HP_W-1:0]   half_per_ff;
   logic [mwem_pkg::TMO_W-1:0]  busy_tmo_ff;
   logic [mwem_pkg::TMO_W-1:0]  ready_tmo_ff;

   mwem_pkg::item_type   front_item;
   mwem_pkg::item_type   back_item;
   mwem_pkg::timing_type timing;
   mwem_pkg::result_type res;
   logic                 q_not_full;
   logic                 q_not_empty;
   logic                 q_pop;

   assign csr_ready  = 1'b1;
   assign req_tready = q_not_full;

   assign timing.half_per  = half_per_ff;
   assign timing.busy_tmo  = busy_tmo_ff;
   assign timing.ready_tmo = ready_tmo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff      <= 1'b0;
         half_per_ff  <= mwem_pkg::HALF_PER_RESET;
         busy_tmo_ff  <= mwem_pkg::BUSY_TMO_RESET;
         ready_tmo_ff <= mwem_pkg::READY_TMO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mwem_pkg::CSR_WIDE_ADDR: wide_ff      <= csr_data[0];
            mwem_pkg::CSR_HALF_PER:  half_per_ff  <= csr_data[mwem_pkg::HP_W-1:0];
            mwem_pkg::CSR_BUSY_TMO:  busy_tmo_ff  <= csr_data[mwem_pkg::TMO_W-1:0];
            mwem_pkg::CSR_READY_TMO: ready_tmo_ff <= csr_data[mwem_pkg::TMO_W-1:0];
            default: ;
         endcase
      end
   end

   mwem_front u_front (
      .op              (req_tdata[2:0]),
      .word_address    (req_tdata[10:3]),
      .write_word      (req_tdata[26:11]),
      .serial_data_out (req_tdata[27]),
      .wide_address    (wide_ff),
      .item            (front_item)
   );

   mwem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && q_not_full),
      .push_data (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .pop_data  (back_item),
      .not_empty (q_not_empty)
   );

   mwem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (back_item),
      .item_pop   (q_pop),
      .timing     (timing),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   assign rsp_tdata = {res.status, res.read_word, res.done, res.pm,
                       res.di, res.sk, res.cs, res.pm};

endmodule

`default_nettype wire

### verif/tb_microwire_eeprom_master_core.sv
module tb_microwire_eeprom_master_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mwem_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   // leading bits of each command, sent ahead of the address
   localparam int unsigned LEAD_READ    = 6;
   localparam int unsigned LEAD_WRITE   = 5;
   localparam int unsigned LEAD_ERASE   = 7;
   localparam int unsigned LEAD_CONTROL = 4;
   localparam int unsigned EWEN_PATTERN = 'h30;

   localparam int LEAD_READ_BITS = 5;
   localparam int LEAD_BITS      = 3;

   // data-out level outside the busy and ready waits
   localparam int FILL_LOW    = 0;
   localparam int FILL_HIGH   = 1;
   localparam int FILL_RANDOM = 2;

   localparam int RANDOM_TICKS = 1550;

   typedef struct packed {
      logic                 program_mode;
      logic                 chip_select;
      logic                 serial_clock;
      logic                 serial_data_in;
      logic                 busy;
      logic                 done;
      logic [DATA_BITS-1:0] read_word;
      logic [STATUS_W-1:0]  status;
   } eeprom_pins_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // sequencer copy kept in step with every accepted transfer
   phase_type            seq_phase   = PH_IDLE;
   logic [OP_W-1:0]      seq_op      = OP_NONE;
   logic [CMD_BITS-1:0]  cmd_shift   = '0;
   logic [NBITS_W-1:0]   bits_left   = '0;
   logic [DATA_BITS-1:0] data_shift  = '0;
   logic [HP_W-1:0]      tick_delay  = '0;
   logic [TMO_W-1:0]     wait_left   = '0;
   logic [STATUS_W-1:0]  last_status = ST_OK;

   logic                 cfg_wide_addr   = 1'b0;
   logic [HP_W-1:0]      cfg_half_period = HALF_PER_RESET;
   logic [TMO_W-1:0]     cfg_busy_tmo    = BUSY_TMO_RESET;
   logic [TMO_W-1:0]     cfg_ready_tmo   = READY_TMO_RESET;

   eeprom_pins_t pending_pins[$];

   int  mismatches     = 0;
   int  items_sent     = 0;
   int  reg_writes     = 0;
   int  commands_run[8];
   int  status_seen[4];
   bit  quiet          = 1'b0;
   int  rsp_hold       = 0;

   microwire_eeprom_master_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic void load_delay(phase_type nxt);
      seq_phase  = nxt;
      tick_delay = (cfg_half_period == 0) ? 8'd1 : cfg_half_period;
   endfunction

   function automatic bit delay_done();
      if (tick_delay > 8'd1) begin
         tick_delay = tick_delay - 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void next_bit_or_release();
      if (bits_left != 0) load_delay(PH_BIT_LOW);
      else load_delay(PH_RELEASE);
   endfunction

   function automatic void arm_wait(phase_type nxt, logic [TMO_W-1:0] limit);
      seq_phase = nxt;
      wait_left = (limit == 0) ? 20'd1 : limit;
   endfunction

   function automatic bit end_command(logic [STATUS_W-1:0] st);
      last_status = st;
      seq_phase   = PH_IDLE;
      return 1'b1;
   endfunction

   function automatic void start_command(logic [OP_W-1:0] op, logic [7:0] addr,
                                         logic [DATA_BITS-1:0] word);
      int unsigned abits, a, cmd, nbits;
      abits = cfg_wide_addr ? MAX_ADDR_BITS : NARROW_ADDR_BITS;
      a     = addr & ((1 << abits) - 1);
      nbits = LEAD_BITS + abits;
      case (op)
         OP_READ: begin
            cmd   = (LEAD_READ << abits) | a;
            nbits = LEAD_READ_BITS + abits;
         end
         OP_WRITE: begin
            cmd   = (((LEAD_WRITE << abits) | a) << DATA_BITS) | word;
            nbits = LEAD_BITS + abits + DATA_BITS;
         end
         OP_ERASE: cmd = (LEAD_ERASE << abits) | a;
         OP_WREN:  cmd = (LEAD_CONTROL << abits) | (EWEN_PATTERN << (abits - NARROW_ADDR_BITS));
         default:  cmd = LEAD_CONTROL << abits;
      endcase
      seq_op    = op;
      cmd_shift = cmd[CMD_BITS-1:0];
      bits_left = nbits[NBITS_W-1:0];
      load_delay(PH_SETUP);
   endfunction

   // one tick of the sequencer, returns the pin levels after it
   function automatic eeprom_pins_t advance_sequencer(logic [OP_W-1:0] op, logic [7:0] addr,
                                                      logic [DATA_BITS-1:0] word, logic sdo);
      eeprom_pins_t p;
      bit done;
      done = 1'b0;
      case (seq_phase)
         PH_IDLE: if (op >= OP_READ && op <= OP_WRDS) start_command(op, addr, word);
         PH_SETUP: if (delay_done()) next_bit_or_release();
         PH_BIT_LOW: if (delay_done()) load_delay(PH_BIT_HIGH);
         PH_BIT_HIGH: if (delay_done()) begin
            if (bits_left != 0) bits_left = bits_left - 1'b1;
            next_bit_or_release();
         end
         PH_RELEASE: if (delay_done()) begin
            if (seq_op == OP_READ) begin
               data_shift = '0;
               bits_left  = DATA_BITS;
               load_delay(PH_RD_HIGH);
            end else if (seq_op == OP_WRITE || seq_op == OP_ERASE) begin
               load_delay(PH_CS_DROP);
            end else begin
               done = end_command(ST_OK);
            end
         end
         PH_RD_HIGH: if (delay_done()) begin
            data_shift = {data_shift[DATA_BITS-2:0], sdo};
            load_delay(PH_RD_LOW);
         end
         PH_RD_LOW: if (delay_done()) begin
            if (bits_left != 0) bits_left = bits_left - 1'b1;
            if (bits_left != 0) load_delay(PH_RD_HIGH);
            else done = end_command(ST_OK);
         end
         PH_CS_DROP: if (delay_done()) arm_wait(PH_WAIT_BUSY, cfg_busy_tmo);
         PH_WAIT_BUSY: begin
            if (!sdo) arm_wait(PH_WAIT_READY, cfg_ready_tmo);
            else if (wait_left <= 20'd1) done = end_command(ST_NO_BUSY);
            else wait_left = wait_left - 1'b1;
         end
         PH_WAIT_READY: begin
            if (sdo) done = end_command(ST_OK);
            else if (wait_left <= 20'd1) done = end_command(ST_NO_READY);
            else wait_left = wait_left - 1'b1;
         end
         default: seq_phase = PH_IDLE;
      endcase
      p.program_mode   = (seq_phase != PH_IDLE);
      p.chip_select    = p.program_mode && seq_phase != PH_CS_DROP;
      p.serial_clock   = (seq_phase == PH_BIT_HIGH || seq_phase == PH_RD_HIGH);
      p.serial_data_in = 1'b0;
      if ((seq_phase == PH_BIT_LOW || seq_phase == PH_BIT_HIGH) &&
          bits_left >= 1 && bits_left <= CMD_BITS)
         p.serial_data_in = cmd_shift[bits_left-1];
      p.busy      = p.program_mode;
      p.done      = done;
      p.read_word = data_shift;
      p.status    = last_status;
      return p;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      eeprom_pins_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pins.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual %h", $time, rsp_tdata);
         end else begin
            want = pending_pins.pop_front();
            compare_field("program_mode", want.program_mode, rsp_tdata[0]);
            compare_field("chip_select", want.chip_select, rsp_tdata[1]);
            compare_field("serial_clock", want.serial_clock, rsp_tdata[2]);
            compare_field("serial_data_in", want.serial_data_in, rsp_tdata[3]);
            compare_field("busy_res", want.busy, rsp_tdata[4]);
            compare_field("done_res", want.done, rsp_tdata[5]);
            compare_field("read_word", want.read_word, rsp_tdata[21:6]);
            compare_field("status", want.status, rsp_tdata[23:22]);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_hold = idle_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_tick(logic [OP_W-1:0] op, logic [7:0] addr,
                            logic [DATA_BITS-1:0] word, logic sdo);
      int gap;
      eeprom_pins_t p;
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, sdo, word, addr, op};
      do @(posedge clock); while (!req_tready);
      p = advance_sequencer(op, addr, word, sdo);
      pending_pins.push_back(p);
      items_sent++;
      if (p.done) status_seen[p.status]++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_pins.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         CSR_WIDE_ADDR: cfg_wide_addr   = val[0];
         CSR_HALF_PER:  cfg_half_period = val[HP_W-1:0];
         CSR_BUSY_TMO:  cfg_busy_tmo    = val;
         CSR_READY_TMO: cfg_ready_tmo   = val;
         default: ;
      endcase
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] wide, logic [CSR_DATA_W-1:0] half_per,
                            logic [CSR_DATA_W-1:0] busy_tmo, logic [CSR_DATA_W-1:0] ready_tmo);
      wait_drained();
      write_register(CSR_WIDE_ADDR, wide);
      write_register(CSR_HALF_PER, half_per);
      write_register(CSR_BUSY_TMO, busy_tmo);
      write_register(CSR_READY_TMO, ready_tmo);
      csr_valid <= 1'b0;
   endtask

   function automatic logic line_level(int fill);
      if (fill == FILL_RANDOM) return $urandom_range(0, 1);
      return (fill == FILL_HIGH);
   endfunction

   task automatic send_ignored(int n);
      logic [OP_W-1:0] op;
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: op = OP_NONE;
            1: op = OP_SPARE6;
            default: op = OP_SPARE7;
         endcase
         send_tick(op, $urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 1));
      end
   endtask

   // issue one command and feed ticks until the sequencer is idle again;
   // data-out goes low after busy_after wait ticks and high after ready_after
   task automatic run_command(logic [OP_W-1:0] op, logic [7:0] addr, logic [DATA_BITS-1:0] word,
                              int busy_after, int ready_after, int fill);
      int busy_ticks, ready_ticks;
      logic sdo;
      busy_ticks  = 0;
      ready_ticks = 0;
      commands_run[op]++;
      send_tick(op, addr, word, line_level(fill));
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 299) == 0) wait_drained();
         if (seq_phase == PH_WAIT_BUSY) begin
            sdo = (busy_ticks < busy_after);
            busy_ticks++;
         end else if (seq_phase == PH_WAIT_READY) begin
            sdo = (ready_ticks >= ready_after);
            ready_ticks++;
         end else begin
            sdo = line_level(fill);
         end
         // commands offered mid-sequence must be ignored
         send_tick($urandom_range(OP_NONE, OP_SPARE7), $urandom_range(0, 255),
                   $urandom_range(0, 65535), sdo);
      end
   endtask

   task automatic test_reset_defaults();
      quiet = 1'b1;
      send_ignored(3);
      run_command(OP_READ, 8'hFF, 16'h0000, 0, 0, FILL_HIGH);
      run_command(OP_WRITE, 8'h00, 16'hFFFF, 2, 5, FILL_RANDOM);
      // busy never seen within the default timeout
      run_command(OP_ERASE, 8'h3F, 16'h0000, 2000, 0, FILL_RANDOM);
      quiet = 1'b0;
   endtask

   task automatic test_control_commands();
      configure(20'd0, 20'd1, 20'd8, 20'd8);
      run_command(OP_WREN, 8'h00, 16'h0000, 0, 0, FILL_RANDOM);
      run_command(OP_WRDS, 8'hFF, 16'hFFFF, 0, 0, FILL_RANDOM);
      send_ignored(4);
      configure(20'd1, 20'd1, 20'd8, 20'd8);
      run_command(OP_WREN, 8'hFF, 16'hFFFF, 0, 0, FILL_RANDOM);
      run_command(OP_WRDS, 8'h00, 16'h0000, 0, 0, FILL_RANDOM);
   endtask

   task automatic test_read_words();
      configure(20'd1, 20'd2, 20'd8, 20'd8);
      run_command(OP_READ, 8'hA5, 16'hFFFF, 0, 0, FILL_RANDOM);
      run_command(OP_READ, 8'h00, 16'h0000, 0, 0, FILL_LOW);
      configure(20'd0, 20'd1, 20'd8, 20'd8);
      run_command(OP_READ, 8'hC0, 16'h5A5A, 0, 0, FILL_HIGH);
      run_command(OP_READ, 8'h3F, 16'h0000, 0, 0, FILL_RANDOM);
   endtask

   task automatic test_program_status();
      configure(20'd0, 20'd1, 20'd1, 20'd1);
      run_command(OP_WRITE, 8'h15, 16'hA5A5, 0, 0, FILL_RANDOM);
      run_command(OP_ERASE, 8'h2A, 16'h0000, 1, 0, FILL_RANDOM);
      run_command(OP_WRITE, 8'h3F, 16'h0000, 0, 1, FILL_RANDOM);
      // zero timeouts behave as one tick
      configure(20'd1, 20'd1, 20'd0, 20'd0);
      run_command(OP_ERASE, 8'hFF, 16'h0000, 0, 1, FILL_RANDOM);
      run_command(OP_WRITE, 8'h80, 16'h8001, 1, 0, FILL_RANDOM);
      // one tick either side of each timeout
      configure(20'd1, 20'd1, 20'd6, 20'd9);
      run_command(OP_WRITE, 8'h7F, 16'h1234, 5, 8, FILL_RANDOM);
      run_command(OP_ERASE, 8'h01, 16'h0000, 6, 0, FILL_RANDOM);
      run_command(OP_WRITE, 8'hFE, 16'hFEDC, 0, 9, FILL_RANDOM);
   endtask

   task automatic test_timing_extremes();
      quiet = 1'b1;
      configure(20'd0, 20'd255, 20'hFFFFF, 20'hFFFFF);
      run_command(OP_ERASE, 8'h2D, 16'h0000, 100, 300, FILL_RANDOM);
      // zero half period behaves as one tick
      configure(20'd1, 20'd0, 20'hFFFFF, 20'hFFFFF);
      run_command(OP_WRITE, 8'hC3, 16'h0F0F, 20, 50, FILL_RANDOM);
      run_command(OP_WREN, 8'h11, 16'h0000, 0, 0, FILL_RANDOM);
      // only the low bits of the address-width and half-period registers take effect
      configure(20'hFFFFE, 20'hABC03, 20'h00005, 20'h80000);
      run_command(OP_READ, 8'hE7, 16'h0000, 0, 0, FILL_RANDOM);
      run_command(OP_WRITE, 8'h59, 16'h7E81, 3, 12, FILL_RANDOM);
      quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      int start_count, r, busy_tmo, ready_tmo, half_per, cmds;
      start_count = items_sent;
      busy_tmo    = 1;
      ready_tmo   = 1;
      cmds        = 0;
      while (items_sent - start_count < RANDOM_TICKS) begin
         if (cmds % 4 == 0) begin
            r        = $urandom_range(0, 9);
            half_per = (r < 6) ? 1 : (r < 9) ? $urandom_range(2, 3) : $urandom_range(4, 9);
            busy_tmo  = $urandom_range(1, 24);
            ready_tmo = $urandom_range(1, 40);
            configure($urandom_range(0, 1), half_per, busy_tmo, ready_tmo);
         end
         quiet = ($urandom_range(0, 4) == 0);
         run_command($urandom_range(OP_READ, OP_WRDS), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, busy_tmo + 1),
                     $urandom_range(0, ready_tmo + 1), FILL_RANDOM);
         send_ignored($urandom_range(0, 3));
         cmds++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_control_commands();
      test_read_words();
      test_program_status();
      test_timing_extremes();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d ticks: %0d reads, %0d writes, %0d erases, %0d enables, %0d disables",
               items_sent, commands_run[OP_READ], commands_run[OP_WRITE],
               commands_run[OP_ERASE], commands_run[OP_WREN], commands_run[OP_WRDS]);
      $display("finished ok %0d, busy missing %0d, ready missing %0d; %0d register writes",
               status_seen[ST_OK], status_seen[ST_NO_BUSY], status_seen[ST_NO_READY],
               reg_writes);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
